// ----- design/epsc_pkg.sv -----
package epsc_pkg;

  // input saturation point: 2099-12-31 23:59:59
  localparam logic [31:0] MaxSeconds = 32'd4102444799;

  localparam logic [16:0] SecsPerDay = 17'd86400;
  localparam logic [5:0]  SecsPerMin = 6'd60;

  // days = (secs >> 7) / 675, exact by reciprocal for 25-bit operands
  localparam logic [25:0] DayRecip = 26'd50903317;
  localparam int          DayShift = 35;

  // x / 60 = (x >> 2) / 15, exact by reciprocal for up to 15-bit operands
  localparam logic [15:0] MinRecip = 16'd34953;
  localparam int          MinShift = 19;

  // four-year cycles counted from 1968-01-01 (a leap year)
  localparam logic [16:0] CycRecip      = 17'd91868;
  localparam int          CycShift      = 27;
  localparam logic [10:0] DaysPerCycle  = 11'd1461;
  localparam logic [9:0]  EpochToCycle  = 10'd731;
  localparam logic [11:0] CycleBaseYear = 12'd1968;

  // first day of year offsets within a four-year period
  localparam logic [10:0] Year1Start = 11'd366;
  localparam logic [10:0] Year2Start = 11'd731;
  localparam logic [10:0] Year3Start = 11'd1096;

  localparam int MonthsPerYear = 12;

  // day of year on which month mo (0 = January) begins
  function automatic logic [8:0] month_start(input logic [3:0] mo, input logic leap);
    logic [8:0] base;
    case (mo)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (leap && (mo >= 4'd2)) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

endpackage

// ----- design/epsc_clock_split.sv -----
module epsc_clock_split import epsc_pkg::*; (
  input  logic        clk_i,
  input  logic [16:0] sod_i,
  output logic [4:0]  hour_o,
  output logic [5:0]  minute_o,
  output logic [5:0]  second_o
);

  // stage a: total minutes of the day
  logic [30:0] min_prod;
  logic [10:0] mtot_a_q;
  logic [16:0] sod_a_q;

  assign min_prod = {16'd0, sod_i[16:2]} * {15'd0, MinRecip};

  always_ff @(posedge clk_i) begin
    mtot_a_q <= min_prod[MinShift+10:MinShift];
    sod_a_q  <= sod_i;
  end

  // stage b: seconds remainder and hour
  logic [16:0] min_secs;
  logic [16:0] sec_full;
  logic [24:0] hr_prod;
  logic [4:0]  hr_b_q;
  logic [5:0]  sec_b_q;
  logic [10:0] mtot_b_q;

  assign min_secs = {6'd0, mtot_a_q} * {11'd0, SecsPerMin};
  assign sec_full = sod_a_q - min_secs;
  assign hr_prod  = {16'd0, mtot_a_q[10:2]} * {9'd0, MinRecip};

  always_ff @(posedge clk_i) begin
    hr_b_q   <= hr_prod[MinShift+4:MinShift];
    sec_b_q  <= sec_full[5:0];
    mtot_b_q <= mtot_a_q;
  end

  // stage c: minute remainder, output registers
  logic [10:0] hr_mins;
  logic [10:0] min_full;
  logic [4:0]  hour_q;
  logic [5:0]  minute_q;
  logic [5:0]  second_q;

  assign hr_mins  = {6'd0, hr_b_q} * {5'd0, SecsPerMin};
  assign min_full = mtot_b_q - hr_mins;

  always_ff @(posedge clk_i) begin
    hour_q   <= hr_b_q;
    minute_q <= min_full[5:0];
    second_q <= sec_b_q;
  end

  assign hour_o   = hour_q;
  assign minute_o = minute_q;
  assign second_o = second_q;

endmodule

// ----- design/epsc_date_split.sv -----
module epsc_date_split import epsc_pkg::*; (
  input  logic        clk_i,
  input  logic [15:0] cyc_days_i,
  input  logic [5:0]  cyc_i,
  output logic [11:0] year_o,
  output logic [3:0]  month_o,
  output logic [4:0]  day_o,
  output logic [8:0]  doy_o,
  output logic        leap_o
);

  // stage a: day within the four-year cycle
  logic [15:0] cyc_span;
  logic [15:0] rem_full;
  logic [10:0] rem_a_q;
  logic [5:0]  cyc_a_q;

  assign cyc_span = {10'd0, cyc_i} * {5'd0, DaysPerCycle};
  assign rem_full = cyc_days_i - cyc_span;

  always_ff @(posedge clk_i) begin
    rem_a_q <= rem_full[10:0];
    cyc_a_q <= cyc_i;
  end

  // stage b: year within the cycle, day of year
  logic [1:0]  yoff;
  logic [10:0] ystart;
  logic [10:0] doy_full;
  logic [11:0] year_b_q;
  logic [8:0]  doy_b_q;
  logic        leap_b_q;

  always_comb begin
    if (rem_a_q >= Year3Start) begin
      yoff   = 2'd3;
      ystart = Year3Start;
    end else if (rem_a_q >= Year2Start) begin
      yoff   = 2'd2;
      ystart = Year2Start;
    end else if (rem_a_q >= Year1Start) begin
      yoff   = 2'd1;
      ystart = Year1Start;
    end else begin
      yoff   = 2'd0;
      ystart = 11'd0;
    end
  end

  assign doy_full = rem_a_q - ystart;

  always_ff @(posedge clk_i) begin
    year_b_q <= CycleBaseYear + {4'd0, cyc_a_q, yoff};
    doy_b_q  <= doy_full[8:0];
    leap_b_q <= (yoff == 2'd0);
  end

  // stage c: month and day of month, output registers
  logic [3:0]  mo_idx;
  logic [8:0]  dom_full;
  logic [11:0] year_q;
  logic [3:0]  month_q;
  logic [4:0]  day_q;
  logic [8:0]  doy_q;
  logic        leap_q;

  always_comb begin
    mo_idx = 4'd0;
    for (int k = 1; k < MonthsPerYear; k++) begin
      mo_idx = mo_idx + 4'(doy_b_q >= month_start(4'(k), leap_b_q));
    end
  end

  assign dom_full = doy_b_q - month_start(mo_idx, leap_b_q) + 9'd1;

  always_ff @(posedge clk_i) begin
    year_q  <= year_b_q;
    month_q <= mo_idx + 4'd1;
    day_q   <= dom_full[4:0];
    doy_q   <= doy_b_q;
    leap_q  <= leap_b_q;
  end

  assign year_o  = year_q;
  assign month_o = month_q;
  assign day_o   = day_q;
  assign doy_o   = doy_q;
  assign leap_o  = leap_q;

endmodule

// ----- design/epoch_seconds_to_calendar.sv -----
// Converts seconds since 1970-01-01 00:00:00 into calendar date and time of
// day for the years 1970 through 2099; inputs past the end of 2099 saturate to
// 2099-12-31 23:59:59. The block holds no state beyond its pipeline registers.
// It is a five-stage pipeline fed by constant-reciprocal multipliers: a new
// timestamp is taken every cycle (busy_o stays low), and its result appears
// with done_o high as it leaves the last stage, for one cycle only. The
// receiver must capture the result in that cycle.
module epoch_seconds_to_calendar import epsc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] epoch_seconds_i,
  output logic        done_o,
  output logic [11:0] year_number_o,
  output logic [3:0]  month_number_o,
  output logic [4:0]  day_of_month_o,
  output logic [4:0]  hour_of_day_o,
  output logic [5:0]  minute_of_hour_o,
  output logic [5:0]  second_of_minute_o,
  output logic [8:0]  day_of_year_o,
  output logic        is_leap_year_o,
  output logic [15:0] days_since_epoch_o
);

  localparam int Depth = 5;

  // valid bits travel alongside the data
  logic [Depth-1:0] vld_q;
  logic [Depth-1:0] vld_d;

  assign vld_d = {vld_q[Depth-2:0], start_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // stage 1: saturate and whole days
  logic [31:0] secs_sat;
  logic [50:0] day_prod;
  logic [31:0] secs1_q;
  logic [15:0] days1_q;

  assign secs_sat = (epoch_seconds_i > MaxSeconds) ? MaxSeconds : epoch_seconds_i;
  assign day_prod = {26'd0, secs_sat[31:7]} * {25'd0, DayRecip};

  always_ff @(posedge clk_i) begin
    secs1_q <= secs_sat;
    days1_q <= day_prod[DayShift+15:DayShift];
  end

  // stage 2: seconds of day and four-year cycle number
  logic [32:0] day_secs;
  logic [16:0] sod_d;
  logic [15:0] cyc_days;
  logic [32:0] cyc_prod;
  logic [16:0] sod2_q;
  logic [15:0] cyc_days2_q;
  logic [5:0]  cyc2_q;
  logic [15:0] days2_q;

  assign day_secs = {17'd0, days1_q} * {16'd0, SecsPerDay};
  assign sod_d    = secs1_q[16:0] - day_secs[16:0];
  assign cyc_days = days1_q + {6'd0, EpochToCycle};
  assign cyc_prod = {17'd0, cyc_days} * {16'd0, CycRecip};

  always_ff @(posedge clk_i) begin
    sod2_q      <= sod_d;
    cyc_days2_q <= cyc_days;
    cyc2_q      <= cyc_prod[CycShift+5:CycShift];
    days2_q     <= days1_q;
  end

  // stages 3 to 5: time of day and date in parallel
  epsc_clock_split u_clock (
    .clk_i    (clk_i),
    .sod_i    (sod2_q),
    .hour_o   (hour_of_day_o),
    .minute_o (minute_of_hour_o),
    .second_o (second_of_minute_o)
  );

  epsc_date_split u_date (
    .clk_i      (clk_i),
    .cyc_days_i (cyc_days2_q),
    .cyc_i      (cyc2_q),
    .year_o     (year_number_o),
    .month_o    (month_number_o),
    .day_o      (day_of_month_o),
    .doy_o      (day_of_year_o),
    .leap_o     (is_leap_year_o)
  );

  // day count delay line matching the split units
  logic [15:0] days3_q;
  logic [15:0] days4_q;
  logic [15:0] days5_q;

  always_ff @(posedge clk_i) begin
    days3_q <= days2_q;
    days4_q <= days3_q;
    days5_q <= days4_q;
  end

  assign days_since_epoch_o = days5_q;
  assign done_o             = vld_q[Depth-1];
  assign busy_o             = 1'b0;

  // result sanity checks
  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (hour_of_day_o <= 5'd23) && (minute_of_hour_o <= 6'd59)
               && (second_of_minute_o <= 6'd59))
    else $error("time of day out of range");

  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (month_number_o >= 4'd1) && (month_number_o <= 4'd12)
               && (day_of_month_o >= 5'd1) && (day_of_year_o <= 9'd365))
    else $error("date out of range");

  a_leap_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (is_leap_year_o == (year_number_o[1:0] == 2'd0)))
    else $error("leap flag disagrees with year");

  a_year_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (year_number_o >= 12'd1970) && (year_number_o <= 12'd2099)
               && (days_since_epoch_o <= 16'd47481))
    else $error("year out of range");

endmodule

// ----- verif/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] MaxEpochSeconds = 32'd4102444799;
  localparam int unsigned SecsPerDay      = 86400;
  localparam int unsigned SecsPerHour     = 3600;
  localparam int unsigned SecsPerMinute   = 60;
  localparam int unsigned FirstYear       = 1970;
  localparam int unsigned LastYear        = 2099;
  localparam int          RandomStamps    = 1230;
  localparam int          DrainSpacing    = 250;
  localparam int          IdleLimit       = 1000;
  localparam int          TailCycles      = 12;
  localparam int          ReportLimit     = 10;

  // one converted timestamp as the block presents it
  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  mday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [8:0]  yday;
    logic        leap;
    logic [15:0] day_count;
  } calendar_t;

  // timestamp waiting to be sent; drain holds it back until the pipe is empty
  typedef struct {
    logic [31:0] secs;
    bit          drain;
  } stamp_req_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [31:0] epoch_seconds_i;
  logic        done_o;
  logic [11:0] year_number_o;
  logic [3:0]  month_number_o;
  logic [4:0]  day_of_month_o;
  logic [4:0]  hour_of_day_o;
  logic [5:0]  minute_of_hour_o;
  logic [5:0]  second_of_minute_o;
  logic [8:0]  day_of_year_o;
  logic        is_leap_year_o;
  logic [15:0] days_since_epoch_o;

  stamp_req_t pending_stamps[$];
  calendar_t  expected_dates[$];
  int         mismatch_count;
  int         idle_cycles;
  int         burst_left;
  int         gap_left;

  epoch_seconds_to_calendar u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .epoch_seconds_i    (epoch_seconds_i),
    .done_o             (done_o),
    .year_number_o      (year_number_o),
    .month_number_o     (month_number_o),
    .day_of_month_o     (day_of_month_o),
    .hour_of_day_o      (hour_of_day_o),
    .minute_of_hour_o   (minute_of_hour_o),
    .second_of_minute_o (second_of_minute_o),
    .day_of_year_o      (day_of_year_o),
    .is_leap_year_o     (is_leap_year_o),
    .days_since_epoch_o (days_since_epoch_o)
  );

  // clock
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // divisible-by-four rule, exact over 1970..2099
  function automatic bit leap_year(input int unsigned yr);
    return (yr % 4) == 0;
  endfunction

  function automatic int unsigned year_len(input int unsigned yr);
    return leap_year(yr) ? 366 : 365;
  endfunction

  // mo counts from 1 (January)
  function automatic int unsigned month_len(input int unsigned mo, input bit leap);
    case (mo)
      2:           return leap ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  // expected calendar fields for one timestamp, saturating past 2099
  function automatic calendar_t calendar_of(input logic [31:0] raw);
    int unsigned secs;
    int unsigned days;
    int unsigned sod;
    int unsigned rem;
    int unsigned yr;
    int unsigned mo;
    calendar_t   c;
    secs = (raw > MaxEpochSeconds) ? MaxEpochSeconds : raw;
    days = secs / SecsPerDay;
    sod  = secs % SecsPerDay;
    yr   = FirstYear;
    rem  = days;
    while (rem >= year_len(yr)) begin
      rem -= year_len(yr);
      yr++;
    end
    c.yday = 9'(rem);
    c.leap = leap_year(yr);
    mo = 1;
    while (mo < 12 && rem >= month_len(mo, c.leap)) begin
      rem -= month_len(mo, c.leap);
      mo++;
    end
    c.year      = 12'(yr);
    c.month     = 4'(mo);
    c.mday      = 5'(rem + 1);
    c.hour      = 5'(sod / SecsPerHour);
    c.minute    = 6'((sod % SecsPerHour) / SecsPerMinute);
    c.second    = 6'(sod % SecsPerMinute);
    c.day_count = 16'(days);
    return c;
  endfunction

  // timestamp of a given civil date and time
  function automatic logic [31:0] seconds_at(input int unsigned yr, input int unsigned mo,
                                             input int unsigned d, input int unsigned h,
                                             input int unsigned mi, input int unsigned s);
    int unsigned days;
    days = 0;
    for (int unsigned y = FirstYear; y < yr; y++) days += year_len(y);
    for (int unsigned m = 1; m < mo; m++) days += month_len(m, leap_year(yr));
    days += d - 1;
    return days * SecsPerDay + h * SecsPerHour + mi * SecsPerMinute + s;
  endfunction

  function automatic string fmt_date(input calendar_t c);
    return $sformatf("%0d-%0d-%0d %0d:%0d:%0d yday %0d leap %0d days %0d",
                     c.year, c.month, c.mday, c.hour, c.minute, c.second,
                     c.yday, c.leap, c.day_count);
  endfunction

  function automatic void add_stamp(input logic [31:0] secs, input bit drain);
    stamp_req_t r;
    r.secs  = secs;
    r.drain = drain;
    pending_stamps.push_back(r);
  endfunction

  // random date and time, weighted toward first and last days of the month and day edges
  function automatic logic [31:0] random_date_stamp();
    int unsigned yr;
    int unsigned mo;
    int unsigned d;
    int unsigned dmax;
    int unsigned pick;
    yr   = $urandom_range(FirstYear, LastYear);
    mo   = $urandom_range(1, 12);
    dmax = month_len(mo, leap_year(yr));
    pick = $urandom_range(0, 3);
    d    = (pick == 0) ? 1 : (pick == 1) ? dmax : $urandom_range(1, dmax);
    case ($urandom_range(0, 3))
      0:       return seconds_at(yr, mo, d, 0, 0, 0);
      1:       return seconds_at(yr, mo, d, 23, 59, 59);
      default: return seconds_at(yr, mo, d, $urandom_range(0, 23), $urandom_range(0, 59),
                                 $urandom_range(0, 59));
    endcase
  endfunction

  // driver: bursts of transfers with random gaps between them
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i         <= 1'b0;
      epoch_seconds_i <= '0;
      burst_left      = $urandom_range(1, 40);
      gap_left        = 0;
    end else if (start_i && busy_o) begin
      // hold the current request until it is taken
    end else if (gap_left > 0) begin
      start_i  <= 1'b0;
      gap_left = gap_left - 1;
    end else if (pending_stamps.size() > 0 &&
                 !(pending_stamps[0].drain && (start_i || expected_dates.size() != 0))) begin
      start_i         <= 1'b1;
      epoch_seconds_i <= pending_stamps[0].secs;
      void'(pending_stamps.pop_front());
      if (burst_left <= 1) begin
        burst_left = $urandom_range(1, 60);
        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      end else begin
        burst_left = burst_left - 1;
      end
    end else begin
      start_i <= 1'b0;
    end
  end

  // monitor: records each input transfer and checks each result transfer
  always @(posedge clk_i or negedge rst_ni) begin
    calendar_t got;
    calendar_t want;
    bit        moved;
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else begin
      moved = 1'b0;
      if (start_i && !busy_o) begin
        expected_dates.push_back(calendar_of(epoch_seconds_i));
        moved = 1'b1;
      end
      if (done_o === 1'b1) begin
        moved = 1'b1;
        got = '{year_number_o, month_number_o, day_of_month_o, hour_of_day_o,
                minute_of_hour_o, second_of_minute_o, day_of_year_o, is_leap_year_o,
                days_since_epoch_o};
        if (expected_dates.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= ReportLimit)
            $display("[%0t] result with nothing pending: %s", $realtime, fmt_date(got));
        end else begin
          want = expected_dates.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= ReportLimit)
              $display("[%0t] mismatch: expected %s, actual %s", $realtime,
                       fmt_date(want), fmt_date(got));
          end
        end
      end
      idle_cycles <= moved ? 0 : idle_cycles + 1;
    end
  end

  // stimulus and end of run
  initial begin
    bit timed_out;
    int sel;
    logic [31:0] stamp;
    mismatch_count = 0;
    rst_ni = 1'b0;

    // field extremes, unit rollovers, leap-day edges and saturation
    add_stamp(32'd0, 1'b0);
    add_stamp(32'd59, 1'b0);
    add_stamp(32'd60, 1'b0);
    add_stamp(32'd3599, 1'b0);
    add_stamp(32'd3600, 1'b0);
    add_stamp(32'd86399, 1'b0);
    add_stamp(32'd86400, 1'b0);
    add_stamp(seconds_at(1972, 2, 28, 23, 59, 59), 1'b0);
    add_stamp(seconds_at(1972, 2, 29, 0, 0, 0), 1'b0);
    add_stamp(seconds_at(1972, 3, 1, 0, 0, 0), 1'b0);
    add_stamp(seconds_at(1973, 2, 28, 23, 59, 59), 1'b0);
    add_stamp(seconds_at(1973, 3, 1, 0, 0, 0), 1'b0);
    add_stamp(seconds_at(1972, 12, 31, 23, 59, 59), 1'b0);
    add_stamp(seconds_at(2000, 2, 29, 12, 30, 30), 1'b0);
    add_stamp(seconds_at(2096, 12, 31, 23, 59, 59), 1'b0);
    add_stamp(32'h7FFF_FFFF, 1'b0);
    add_stamp(32'h8000_0000, 1'b0);
    add_stamp(32'h5555_5555, 1'b0);
    add_stamp(32'hAAAA_AAAA, 1'b0);
    add_stamp(MaxEpochSeconds, 1'b0);
    add_stamp(MaxEpochSeconds + 32'd1, 1'b0);
    add_stamp(32'hFFFF_FFFF, 1'b0);

    // random mix; every 250th stamp the sender lets the pipe empty first
    for (int i = 0; i < RandomStamps; i++) begin
      sel = $urandom_range(0, 9);
      if (sel <= 3) begin
        stamp = $urandom_range(0, MaxEpochSeconds);
      end else if (sel == 4) begin
        stamp = $urandom();
      end else if (sel <= 8) begin
        stamp = random_date_stamp();
      end else begin
        stamp = seconds_at($urandom_range(FirstYear, LastYear), $urandom_range(1, 12), 1, 0, 0, 0)
                + $urandom_range(0, 4) - 2;
      end
      add_stamp(stamp, (i % DrainSpacing) == 0);
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // wait for the queue to drain and every result to arrive
    while ((pending_stamps.size() != 0 || start_i || expected_dates.size() != 0) &&
           idle_cycles < IdleLimit)
      @(posedge clk_i);
    timed_out = (idle_cycles >= IdleLimit);
    if (!timed_out) repeat (TailCycles) @(posedge clk_i);

    if (!timed_out && mismatch_count == 0 && expected_dates.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
